@@ hdl/adp_pkg.sv @@
// package: shared types, widths and character codes of the decimal command parser
package adp_pkg;

  localparam int BYTE_W = 8;
  localparam int MANT_W = 50;
  localparam int FRAC_W = 4;
  localparam int TGT_W = 2;
  localparam int STAT_W = 2;
  localparam int PROD_W = MANT_W + 4;
  localparam int MAX_LEN_DEFAULT = 16;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;
  localparam logic [BYTE_W-1:0] ASCII_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] ASCII_S = 8'h53;
  localparam logic [BYTE_W-1:0] ASCII_P = 8'h50;
  localparam logic [BYTE_W-1:0] ASCII_I = 8'h49;
  localparam logic [BYTE_W-1:0] ASCII_D = 8'h44;

  localparam logic [PROD_W-1:0] MANT_MAX = PROD_W'(64'd999999999999999);
  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  typedef enum logic [TGT_W-1:0] {
    TGT_SETPOINT = 2'd0,
    TGT_KP       = 2'd1,
    TGT_KI       = 2'd2,
    TGT_KD       = 2'd3
  } target_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } stage_t;

endpackage

@@ hdl/adp_ifs.sv @@
// interfaces: received byte channel and command result channel
interface adp_rx_if;
  logic                      valid;
  logic                      ready;
  logic [adp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface adp_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [adp_pkg::TGT_W-1:0]  target;
  logic [adp_pkg::MANT_W-1:0] mantissa;
  logic [adp_pkg::FRAC_W-1:0] fraction_digits;
  logic [adp_pkg::STAT_W-1:0] status;

  modport source (output valid, output target, output mantissa, output fraction_digits,
                  output status, input ready);
  modport sink (input valid, input target, input mantissa, input fraction_digits,
                input status, output ready);
endinterface

@@ hdl/ascii_decimal_command_parser_unit.sv @@
// Takes one received byte per cycle on rx and reports each command on cmd. Every
// byte passes an input register before it is folded into the field state, so a
// byte can be accepted every cycle; a command letter passes the input register and
// the result register before it is presented on cmd, and waits in the result
// register until taken, while digits and other bytes keep flowing. Only a command
// letter arriving while an untaken result still occupies the result register
// stalls rx. The mantissa update is one multiply by ten (shift and add) plus a
// digit and a compare.
module ascii_decimal_command_parser_unit #(
  parameter int MAX_LEN = adp_pkg::MAX_LEN_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  adp_rx_if.sink    rx,
  adp_cmd_if.source cmd
);
  import adp_pkg::*;

  stage_t stage;
  logic   take;

  adp_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .take  (take),
    .stage (stage)
  );

  adp_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .stage (stage),
    .take  (take),
    .cmd   (cmd)
  );

endmodule

@@ hdl/adp_in_stage.sv @@
// input register: holds one received byte until the parser consumes it
module adp_in_stage (
  input  logic           clk,
  input  logic           rst,
  adp_rx_if.sink         rx,
  input  logic           take,
  output adp_pkg::stage_t stage
);
  import adp_pkg::*;

  logic              valid;
  logic [BYTE_W-1:0] data;

  assign rx.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.ready) begin
      valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      data <= rx.rx_byte;
    end
  end

  assign stage.valid = valid;
  assign stage.data = data;

endmodule

@@ hdl/adp_core.sv @@
// parser core: field accumulation state and registered command result
module adp_core #(
  parameter int MAX_LEN = adp_pkg::MAX_LEN_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  adp_pkg::stage_t stage,
  output logic            take,
  adp_cmd_if.source       cmd
);
  import adp_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LEN - 1);

  logic [MANT_W-1:0] acc, acc_next;
  logic [FRAC_W-1:0] frac, frac_next;
  logic              point_seen, point_seen_next;
  logic [CNT_W-1:0]  char_count, char_count_next;
  logic              bad_seen, bad_seen_next;

  logic              out_valid;
  target_t           out_target;
  logic [MANT_W-1:0] out_mantissa;
  logic [FRAC_W-1:0] out_frac;
  status_t           out_status;

  logic              is_cmd;
  target_t           tgt;
  logic              is_digit;
  logic [3:0]        digit;
  logic [CNT_W-1:0]  cnt_inc;
  logic [PROD_W-1:0] prod;
  status_t           status;
  logic              load;

  always_comb begin
    is_cmd = 1'b1;
    tgt = TGT_SETPOINT;
    priority case (stage.data)
      ASCII_S: tgt = TGT_SETPOINT;
      ASCII_P: tgt = TGT_KP;
      ASCII_I: tgt = TGT_KI;
      ASCII_D: tgt = TGT_KD;
      default: is_cmd = 1'b0;
    endcase
  end

  assign take = stage.valid && (!is_cmd || !out_valid || cmd.ready);
  assign load = take && is_cmd;

  assign is_digit = (stage.data >= ASCII_ZERO) && (stage.data <= ASCII_NINE);
  assign digit = 4'(stage.data - ASCII_ZERO);
  assign cnt_inc = (char_count >= CNT_LAST) ? CNT_FULL : char_count + 1'b1;
  assign prod = {acc, 3'b000} + {2'b00, acc, 1'b0} + PROD_W'(digit);

  always_comb begin
    if (bad_seen) begin
      status = STATUS_BAD_CHAR;
    end else if (char_count >= CNT_FULL) begin
      status = STATUS_TOO_LONG;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    acc_next = acc;
    frac_next = frac;
    point_seen_next = point_seen;
    char_count_next = char_count;
    bad_seen_next = bad_seen;
    if (take) begin
      if (is_cmd) begin
        acc_next = '0;
        frac_next = '0;
        point_seen_next = 1'b0;
        char_count_next = '0;
        bad_seen_next = 1'b0;
      end else begin
        char_count_next = cnt_inc;
        if (is_digit) begin
          if (cnt_inc < CNT_FULL) begin
            if (prod > MANT_MAX) begin
              char_count_next = CNT_FULL;
            end else begin
              acc_next = prod[MANT_W-1:0];
              if (point_seen && frac != FRAC_MAX) begin
                frac_next = frac + 1'b1;
              end
            end
          end
        end else if (stage.data == ASCII_POINT) begin
          if (point_seen) begin
            bad_seen_next = 1'b1;
          end else begin
            point_seen_next = 1'b1;
          end
        end else begin
          bad_seen_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      frac <= '0;
      point_seen <= 1'b0;
      char_count <= '0;
      bad_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      acc <= acc_next;
      frac <= frac_next;
      point_seen <= point_seen_next;
      char_count <= char_count_next;
      bad_seen <= bad_seen_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (cmd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_target <= tgt;
      out_status <= status;
      out_mantissa <= (status == STATUS_OK) ? acc : '0;
      out_frac <= (status == STATUS_OK) ? frac : '0;
    end
  end

  assign cmd.valid = out_valid;
  assign cmd.target = out_target;
  assign cmd.mantissa = out_mantissa;
  assign cmd.fraction_digits = out_frac;
  assign cmd.status = out_status;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != STATUS_OK) |-> (out_mantissa == '0 && out_frac == '0))
    else $error("error result carries nonzero mantissa or fraction");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    char_count <= CNT_FULL)
    else $error("character count beyond limit");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    {4'b0000, acc} <= MANT_MAX)
    else $error("mantissa beyond fifteen digits");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    load |=> (acc == '0 && char_count == '0 && !point_seen && !bad_seen && out_valid))
    else $error("field state not cleared after command");

  a_frac_point: assert property (@(posedge clk) disable iff (rst)
    (frac != '0) |-> point_seen)
    else $error("fraction digits without point");

endmodule

@@ dv/ascii_decimal_command_parser_unit_test.sv @@
`timescale 1ns / 1ps
// testbench for the decimal command parser: directed and random byte streams checked against a predictor
module ascii_decimal_command_parser_unit_test;
  import adp_pkg::*;

  localparam int FIELD_LIMIT = 16;
  localparam longint unsigned MANT_CEIL = 64'd999999999999999;
  localparam int RANDOM_ITEMS = 1250;
  localparam int BURST_ITEMS = 300;
  localparam int IDLE_PCT = 29;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 50;

  typedef logic [BYTE_W-1:0] char_q_t[$];

  typedef struct {
    target_t           target;
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] fraction_digits;
    status_t           status;
  } command_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  adp_rx_if rx();
  adp_cmd_if cmd();

  ascii_decimal_command_parser_unit #(.MAX_LEN(FIELD_LIMIT)) dut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .cmd(cmd)
  );

  always #5 clk = ~clk;

  // field being assembled by the predictor
  logic [MANT_W-1:0] field_value;
  logic [FRAC_W-1:0] field_fraction;
  logic              field_point;
  logic [4:0]        field_chars;
  logic              field_bad;

  command_t pending_cmds[$];
  command_t taken_cmd;
  logic [BYTE_W-1:0] cmd_letters[4] = '{ASCII_S, ASCII_P, ASCII_I, ASCII_D};

  int errors = 0;
  int requests_sent = 0;
  int commands_checked = 0;
  int status_seen[3] = '{0, 0, 0};
  int send_idle_pct = IDLE_PCT;
  int take_idle_pct = IDLE_PCT;
  int cycles = 0;

  function automatic void clear_field();
    field_value = '0;
    field_fraction = '0;
    field_point = 1'b0;
    field_chars = '0;
    field_bad = 1'b0;
  endfunction

  function automatic void fold_byte(input logic [BYTE_W-1:0] b);
    command_t c;
    logic [3:0] d;
    longint unsigned acc;
    logic is_cmd;
    is_cmd = 1'b1;
    case (b)
      ASCII_S: c.target = TGT_SETPOINT;
      ASCII_P: c.target = TGT_KP;
      ASCII_I: c.target = TGT_KI;
      ASCII_D: c.target = TGT_KD;
      default: is_cmd = 1'b0;
    endcase
    if (is_cmd) begin
      if (field_bad) c.status = STATUS_BAD_CHAR;
      else if (field_chars >= FIELD_LIMIT) c.status = STATUS_TOO_LONG;
      else c.status = STATUS_OK;
      c.mantissa = (c.status == STATUS_OK) ? field_value : '0;
      c.fraction_digits = (c.status == STATUS_OK) ? field_fraction : '0;
      pending_cmds.push_back(c);
      clear_field();
    end else begin
      if (field_chars >= FIELD_LIMIT - 1) field_chars = 5'(FIELD_LIMIT);
      else field_chars = field_chars + 5'd1;
      if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
        d = 4'(b - ASCII_ZERO);
        acc = field_value;
        if (field_chars < FIELD_LIMIT) begin
          if (acc > (MANT_CEIL - d) / 10) begin
            field_chars = 5'(FIELD_LIMIT);
          end else begin
            field_value = MANT_W'(acc * 10 + d);
            if (field_point && field_fraction != FRAC_MAX) field_fraction = field_fraction + 4'd1;
          end
        end
      end else if (b == ASCII_POINT) begin
        if (field_point) field_bad = 1'b1;
        else field_point = 1'b1;
      end else begin
        field_bad = 1'b1;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (errors < PRINT_LIMIT)
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_request(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    fold_byte(b);
    requests_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i]);
  endtask

  task automatic send_random_field();
    char_q_t f;
    int kind;
    int nd;
    int point_pos;
    int extra_pos;
    logic [BYTE_W-1:0] extra;
    kind = $urandom_range(99);
    point_pos = -1;
    extra_pos = -1;
    extra = ASCII_POINT;
    if (kind < 70) begin
      nd = ($urandom_range(3) == 0) ? $urandom_range(13, 15) : $urandom_range(0, 8);
      if ($urandom_range(2) != 0) begin
        if (nd == 15) nd = 14;
        point_pos = $urandom_range(nd);
      end
    end else if (kind < 82) begin
      nd = $urandom_range(16, 20);
      if ($urandom_range(1) != 0) point_pos = $urandom_range(nd);
    end else if (kind < 92) begin
      nd = $urandom_range(1, 10);
      extra_pos = $urandom_range(nd);
      case ($urandom_range(2))
        0: point_pos = $urandom_range(nd);
        1: extra = 8'($urandom_range(255));
        default: extra = ($urandom_range(1) != 0) ? 8'h0D : 8'h0A;
      endcase
    end else begin
      nd = 0;
      repeat ($urandom_range(1, 4)) f.push_back(8'($urandom_range(255)));
    end
    for (int i = 0; i <= nd; i++) begin
      if (i == point_pos) f.push_back(ASCII_POINT);
      if (i == extra_pos) f.push_back(extra);
      if (i < nd) f.push_back(ASCII_ZERO + 8'($urandom_range(9)));
    end
    f.push_back(cmd_letters[$urandom_range(3)]);
    foreach (f[i]) send_request(f[i]);
  endtask

  task automatic test_empty_commands();
    send_string("SPID");
    send_string(".S");
  endtask

  task automatic test_bad_bytes();
    send_request(8'h00);
    send_request(ASCII_P);
    send_request(8'hFF);
    send_request(ASCII_S);
    send_string("1..2D");
  endtask

  task automatic test_max_mantissa();
    send_string("999999999999999P");
  endtask

  task automatic test_too_long();
    send_string("9999999999999999I");
  endtask

  task automatic test_random_fields(input int n);
    int start;
    start = requests_sent;
    while (requests_sent - start < n) send_random_field();
  endtask

  task automatic test_back_to_back(input int n);
    send_idle_pct = 0;
    take_idle_pct = 0;
    test_random_fields(n);
    send_idle_pct = IDLE_PCT;
    take_idle_pct = IDLE_PCT;
  endtask

  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected command, mantissa", cmd.mantissa, 0);
      end else begin
        taken_cmd = pending_cmds.pop_front();
        if (cmd.target !== taken_cmd.target)
          report_mismatch("target", cmd.target, taken_cmd.target);
        if (cmd.mantissa !== taken_cmd.mantissa)
          report_mismatch("mantissa", cmd.mantissa, taken_cmd.mantissa);
        if (cmd.fraction_digits !== taken_cmd.fraction_digits)
          report_mismatch("fraction_digits", cmd.fraction_digits, taken_cmd.fraction_digits);
        if (cmd.status !== taken_cmd.status)
          report_mismatch("status", cmd.status, taken_cmd.status);
        commands_checked++;
        status_seen[int'(taken_cmd.status)]++;
      end
    end
    cmd.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rx.valid = 1'b0;
    rx.rx_byte = '0;
    clear_field();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_commands();
    test_bad_bytes();
    test_max_mantissa();
    test_too_long();
    test_random_fields(RANDOM_ITEMS - BURST_ITEMS);
    test_back_to_back(BURST_ITEMS);
    rx.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes, checked %0d commands in %0d cycles", requests_sent,
             commands_checked, cycles);
    $display("commands by status: ok %0d, bad character %0d, too long %0d", status_seen[0],
             status_seen[1], status_seen[2]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
